[rtl/ptt_pkg.sv]
package ptt_pkg;

  // Sizes
  localparam int TIMER_SLOTS_DEF = 16;
  localparam int RESULT_LIMIT    = 16;
  localparam int LIM_W           = $clog2(RESULT_LIMIT + 1);
  localparam int MODE_W          = 3;
  localparam int ID_W            = 16;
  localparam int VAL_W           = 24;
  localparam int KIND_W          = 2;
  localparam int STAT_W          = 2;

  // Command codes
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RELOAD = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MODIFY = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd5;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ANSWER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUIET   = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd3;

  // One table entry
  typedef struct packed {
    logic [ID_W-1:0]  ident;
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] remaining;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_CLEAR,
    S_WALK,
    S_SHIFT,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ADD,
    WR_TICK,
    WR_RELOAD,
    WR_MODIFY,
    WR_SHIFT
  } wr_op_t;

  typedef enum logic [1:0] {
    ID_ZERO,
    ID_NEXT,
    ID_PEND
  } id_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic                load;
    logic                step;
    wr_op_t              wr_op;
    logic                capture;
    logic                used_inc;
    logic                used_dec;
    logic                used_clr;
    logic                ident_inc;
    logic                emit;
    logic [KIND_W-1:0]   kind;
    logic [STAT_W-1:0]   status;
    id_sel_t             id_sel;
    logic                last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cur_valid;
    logic more;
    logic match;
    logic expire;
    logic cap_ok;
    logic pend_valid;
    logic full;
    logic empty;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/ptt_dpath.sv]
module ptt_dpath import ptt_pkg::*; #(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           st,
  input  logic [ID_W-1:0]    sel_id,
  input  logic [VAL_W-1:0]   period,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  kind,
  output logic [STAT_W-1:0]  status,
  output logic [ID_W-1:0]    result_id,
  output logic               last
);

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

  // Table memory, one read and one write port
  entry_t mem [TIMER_SLOTS];
  entry_t rdata;
  entry_t wdata;
  logic [IDX_W-1:0] waddr;
  logic             we;

  logic [ID_W-1:0]  id_q;
  logic [VAL_W-1:0] per_q;
  logic [CNT_W-1:0] used_count;
  logic [ID_W-1:0]  next_ident;
  logic [CNT_W-1:0] rd_ptr;
  logic [IDX_W-1:0] cur;
  logic             cur_valid;
  logic             pend_valid;
  logic [ID_W-1:0]  pend_id;
  logic [LIM_W-1:0] cnt;
  logic             more;
  logic             out_free;
  logic [VAL_W-1:0] rem_dec;
  logic [VAL_W-1:0] rem_clamp;
  logic             expire;

  assign more      = rd_ptr < used_count;
  assign out_free  = !out_valid || !out_stall;
  assign expire    = rdata.remaining <= VAL_W'(1);
  assign rem_dec   = rdata.remaining - VAL_W'(1);
  assign rem_clamp = (rdata.remaining > per_q) ? per_q : rdata.remaining;

  // Status toward the controller
  always_comb begin
    st.cur_valid  = cur_valid;
    st.more       = more;
    st.match      = rdata.ident == id_q;
    st.expire     = expire;
    st.cap_ok     = cnt < LIM_W'(RESULT_LIMIT);
    st.pend_valid = pend_valid;
    st.full       = used_count == CNT_W'(TIMER_SLOTS);
    st.empty      = used_count == '0;
    st.out_free   = out_free;
  end

  // Select write address and data
  always_comb begin
    we    = 1'b1;
    waddr = cur;
    wdata = rdata;
    case (cmd.wr_op)
      WR_ADD: begin
        waddr = used_count[IDX_W-1:0];
        wdata = '{ident: next_ident, period: per_q, remaining: per_q};
      end
      WR_TICK: begin
        wdata.remaining = expire ? rdata.period : rem_dec;
      end
      WR_RELOAD: begin
        wdata.remaining = rdata.period;
      end
      WR_MODIFY: begin
        wdata.period    = per_q;
        wdata.remaining = rem_clamp;
      end
      WR_SHIFT: begin
        waddr = cur - IDX_W'(1);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Write the table; fetch the next entry on each step
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.step && more) begin
      rdata <= mem[rd_ptr[IDX_W-1:0]];
    end
  end

  // Hold command operands
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_q  <= sel_id;
      per_q <= period;
    end
    if (cmd.step && more) begin
      cur <= rd_ptr[IDX_W-1:0];
    end
    if (cmd.capture) begin
      pend_id <= rdata.ident;
    end
  end

  // Walk pointers, pending expiry, table count, id counter
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr     <= '0;
      cur_valid  <= 1'b0;
      pend_valid <= 1'b0;
      cnt        <= '0;
      used_count <= '0;
      next_ident <= '0;
    end else begin
      if (cmd.load) begin
        rd_ptr     <= '0;
        cur_valid  <= 1'b0;
        pend_valid <= 1'b0;
        cnt        <= '0;
      end else begin
        if (cmd.step) begin
          if (more) begin
            rd_ptr    <= rd_ptr + CNT_W'(1);
            cur_valid <= 1'b1;
          end else begin
            cur_valid <= 1'b0;
          end
        end
        if (cmd.capture) begin
          pend_valid <= 1'b1;
          cnt        <= cnt + LIM_W'(1);
        end
      end
      if (cmd.used_clr) begin
        used_count <= '0;
      end else if (cmd.used_inc) begin
        used_count <= used_count + CNT_W'(1);
      end else if (cmd.used_dec) begin
        used_count <= used_count - CNT_W'(1);
      end
      if (cmd.ident_inc) begin
        next_ident <= next_ident + ID_W'(1);
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind   <= cmd.kind;
      status <= cmd.status;
      last   <= cmd.last;
      case (cmd.id_sel)
        ID_NEXT: result_id <= next_ident;
        ID_PEND: result_id <= pend_id;
        default: result_id <= '0;
      endcase
    end
  end

endmodule

[rtl/ptt_ctrl.sv]
module ptt_ctrl import ptt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] mode,
  input  dp_stat_t          st,
  output dp_cmd_t           cmd
);

  state_t            state;
  state_t            state_next;
  logic [MODE_W-1:0] op;
  logic              found;
  logic              hit;

  assign in_stall = state != S_IDLE;
  assign hit = (state == S_WALK) && st.cur_valid && st.match &&
               (op == MODE_RELOAD || op == MODE_MODIFY);

  // State, command code and match flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= MODE_ADD;
      found <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) begin
        op    <= mode;
        found <= 1'b0;
      end else if (hit) begin
        found <= 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (mode) inside
            MODE_ADD:   state_next = S_ADD;
            MODE_CLEAR: state_next = S_CLEAR;
            MODE_RELOAD, MODE_MODIFY, MODE_REMOVE, MODE_TICK: state_next = S_WALK;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ADD, S_CLEAR, S_FINISH: begin
        if (st.out_free) state_next = S_IDLE;
      end
      S_WALK: begin
        if (!st.cur_valid) begin
          if (!st.more) state_next = S_FINISH;
        end else if (hit) begin
          state_next = S_FINISH;
        end else if (op == MODE_REMOVE && st.match) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!st.cur_valid) state_next = S_FINISH;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd        = '0;
    cmd.kind   = KIND_ANSWER;
    cmd.status = STAT_OK;
    cmd.id_sel = ID_ZERO;
    cmd.last   = 1'b1;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_ADD: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.full) begin
            cmd.status = STAT_FULL;
          end else begin
            cmd.id_sel    = ID_NEXT;
            cmd.wr_op     = WR_ADD;
            cmd.used_inc  = 1'b1;
            cmd.ident_inc = 1'b1;
          end
        end
      end
      S_CLEAR: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.used_clr = 1'b1;
        end
      end
      S_WALK: begin
        if (!st.cur_valid) begin
          cmd.step = st.more;
        end else begin
          case (op)
            MODE_TICK: begin
              if (st.expire && st.cap_ok && st.pend_valid) begin
                // flush the earlier expiry before taking this one
                if (st.out_free) begin
                  cmd.emit    = 1'b1;
                  cmd.kind    = KIND_EXPIRED;
                  cmd.id_sel  = ID_PEND;
                  cmd.last    = 1'b0;
                  cmd.capture = 1'b1;
                  cmd.wr_op   = WR_TICK;
                  cmd.step    = 1'b1;
                end
              end else begin
                cmd.capture = st.expire && st.cap_ok;
                cmd.wr_op   = WR_TICK;
                cmd.step    = 1'b1;
              end
            end
            MODE_RELOAD: begin
              if (st.match) cmd.wr_op = WR_RELOAD;
              else          cmd.step  = 1'b1;
            end
            MODE_MODIFY: begin
              if (st.match) cmd.wr_op = WR_MODIFY;
              else          cmd.step  = 1'b1;
            end
            default: begin
              cmd.step = 1'b1;
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (st.cur_valid) begin
          cmd.wr_op = WR_SHIFT;
          cmd.step  = 1'b1;
        end else begin
          cmd.used_dec = 1'b1;
        end
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          case (op) inside
            MODE_TICK: begin
              if (st.pend_valid) begin
                cmd.kind   = KIND_EXPIRED;
                cmd.id_sel = ID_PEND;
              end else begin
                cmd.kind   = KIND_QUIET;
              end
            end
            MODE_RELOAD, MODE_MODIFY: begin
              if (st.empty)      cmd.status = STAT_EMPTY;
              else if (!found)   cmd.status = STAT_NONE;
            end
            default: begin
              cmd.status = STAT_OK;
            end
          endcase
        end
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

endmodule

[rtl/periodic_timer_table.sv]
// Channel  Valid      Stall      Word
// input    in_valid   in_stall   mode, sel_id, period
// output   out_valid  out_stall  kind, status, result_id, last
//
// Add and clear end once the output register is free for their answer. Reload,
// modify, remove and tick walk the table through its memory, which has one
// read and one write port, one slot per cycle while no earlier expiry waits on
// out_stall, and end once the output register is free for their finished word.
// Reset (rst, synchronous) empties the table and zeroes the id counter.
// in_stall is high whenever a command is in progress.
module periodic_timer_table import ptt_pkg::*; #(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [MODE_W-1:0]  mode,
  input  logic [ID_W-1:0]    sel_id,
  input  logic [VAL_W-1:0]   period,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  kind,
  output logic [STAT_W-1:0]  status,
  output logic [ID_W-1:0]    result_id,
  output logic               last
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  ptt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .st       (st),
    .cmd      (cmd)
  );

  ptt_dpath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .sel_id    (sel_id),
    .period    (period),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .status    (status),
    .result_id (result_id),
    .last      (last)
  );

endmodule
